// ===== sv/kcl_pkg.sv =====
package kcl_pkg;

  // entry buffer length in keys and tag length in bytes
  localparam int PW_KEYS   = 16;
  localparam int TAG_BYTES = 12;

  localparam int KEY_IDX_W = $clog2(PW_KEYS);
  localparam int POS_W     = 5;
  localparam int TAG_IDX_W = $clog2(TAG_BYTES);
  localparam int REF_W     = 96;

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;

  localparam logic [1:0] REG_OPEN_SECONDS = 2'd0;
  localparam logic [1:0] REG_REF_HIGH     = 2'd1;
  localparam logic [1:0] REG_REF_LOW      = 2'd2;

  localparam logic [7:0]  OPEN_SECONDS_RST = 8'd9;
  localparam logic [47:0] REF_HIGH_RST     = 48'h414243443132;  // "ABCD12"
  localparam logic [47:0] REF_LOW_RST      = 48'h464433423536;  // "FD3B56"

  // event kinds
  localparam logic [1:0] CMD_KEY  = 2'd0;
  localparam logic [1:0] CMD_TAG  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [3:0] KEY_STAR = 4'd10;
  localparam logic [3:0] KEY_HASH = 4'd11;

  // result events
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_KEY      = 3'd1;
  localparam logic [2:0] EV_PW_OK    = 3'd2;
  localparam logic [2:0] EV_PW_WRONG = 3'd3;
  localparam logic [2:0] EV_NEW_PW   = 3'd4;
  localparam logic [2:0] EV_SAVED    = 3'd5;
  localparam logic [2:0] EV_TAG_OK   = 3'd6;
  localparam logic [2:0] EV_TAG_WRONG = 3'd7;

  // reported modes
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_CHECK = 2'd1;
  localparam logic [1:0] MODE_OLD   = 2'd2;
  localparam logic [1:0] MODE_NEW   = 2'd3;

  typedef struct packed {
    logic [7:0]  open_seconds;
    logic [47:0] rfid_ref_high;
    logic [47:0] rfid_ref_low;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] key_code;
    logic [7:0] rfid_byte;
  } item_t;

  typedef struct packed {
    logic       door_open;
    logic [7:0] seconds_left;
    logic [2:0] event_res;
    logic [1:0] mode_now;
    logic [4:0] keys_entered;
  } res_t;

endpackage

// ===== sv/kcl_cfg.sv =====
module kcl_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kcl_pkg::ADDR_W-1:0]    paddr,
  input  logic [kcl_pkg::DATA_W-1:0]    pwdata,
  output logic [kcl_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output kcl_pkg::cfg_t                 cfg
);

  kcl_pkg::cfg_t cfg_r;
  logic [1:0]    reg_idx;
  logic          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_seconds  <= kcl_pkg::OPEN_SECONDS_RST;
      cfg_r.rfid_ref_high <= kcl_pkg::REF_HIGH_RST;
      cfg_r.rfid_ref_low  <= kcl_pkg::REF_LOW_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        kcl_pkg::REG_OPEN_SECONDS: cfg_r.open_seconds  <= pwdata[7:0];
        kcl_pkg::REG_REF_HIGH:     cfg_r.rfid_ref_high <= pwdata[47:0];
        kcl_pkg::REG_REF_LOW:      cfg_r.rfid_ref_low  <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      kcl_pkg::REG_OPEN_SECONDS: prdata = {56'd0, cfg_r.open_seconds};
      kcl_pkg::REG_REF_HIGH:     prdata = {16'd0, cfg_r.rfid_ref_high};
      kcl_pkg::REG_REF_LOW:      prdata = {16'd0, cfg_r.rfid_ref_low};
      default:                   prdata = '0;
    endcase
  end

endmodule

// ===== sv/kcl_core.sv =====
module kcl_core (
  input  logic           clk,
  input  logic           rst_n,
  input  kcl_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  kcl_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output kcl_pkg::res_t  out_res
);

  typedef enum logic [1:0] {
    ST_IDLE  = kcl_pkg::MODE_IDLE,
    ST_CHECK = kcl_pkg::MODE_CHECK,
    ST_OLD   = kcl_pkg::MODE_OLD,
    ST_NEW   = kcl_pkg::MODE_NEW
  } mode_t;

  typedef logic [kcl_pkg::PW_KEYS-1:0][3:0]   keys_t;
  typedef logic [kcl_pkg::TAG_BYTES-1:0][7:0] tag_t;

  // input register
  logic           inq_valid_r;
  kcl_pkg::item_t inq_r;

  // lock state
  mode_t                            mode_r, mode_nxt;
  keys_t                            keys_r, keys_nxt, keys_wr;
  keys_t                            saved_r, saved_nxt;
  logic [kcl_pkg::POS_W-1:0]        pos_r, pos_nxt, pos_inc;
  tag_t                             tag_r, tag_nxt, tag_wr;
  logic [kcl_pkg::TAG_IDX_W-1:0]    tpos_r, tpos_nxt;
  logic [kcl_pkg::TAG_IDX_W:0]      tpos_inc;
  logic [7:0]                       cnt_r, cnt_nxt;
  logic [2:0]                       ev;
  logic [kcl_pkg::REF_W-1:0]        ref_all;
  logic                             key_match, tag_match, key_done;

  // result register
  logic          out_valid_r;
  kcl_pkg::res_t res_r;

  logic fire;

  assign fire      = inq_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !inq_valid_r || fire;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign ref_all   = {cfg.rfid_ref_high, cfg.rfid_ref_low};

  always_comb begin
    keys_wr = keys_r;
    keys_wr[pos_r[kcl_pkg::KEY_IDX_W-1:0]] = inq_r.key_code;
    pos_inc   = pos_r + 1'b1;
    key_done  = (inq_r.key_code == kcl_pkg::KEY_HASH) ||
                (pos_inc == kcl_pkg::POS_W'(kcl_pkg::PW_KEYS));
    key_match = (keys_wr == saved_r);

    // tag byte 0 sits in the top lane, like the reference registers
    tag_wr = tag_r;
    tag_wr[kcl_pkg::TAG_IDX_W'(kcl_pkg::TAG_BYTES - 1) - tpos_r] = inq_r.rfid_byte;
    tpos_inc  = {1'b0, tpos_r} + 1'b1;
    tag_match = (tag_wr == ref_all[kcl_pkg::REF_W-1 -: kcl_pkg::TAG_BYTES*8]);
  end

  always_comb begin
    mode_nxt  = mode_r;
    keys_nxt  = keys_r;
    saved_nxt = saved_r;
    pos_nxt   = pos_r;
    tag_nxt   = tag_r;
    tpos_nxt  = tpos_r;
    cnt_nxt   = cnt_r;
    ev        = kcl_pkg::EV_NONE;
    case (inq_r.cmd)
      kcl_pkg::CMD_TICK: begin
        if (cnt_r != 8'd0) begin
          cnt_nxt = cnt_r - 8'd1;
        end
      end
      kcl_pkg::CMD_KEY: begin
        if (cnt_r == 8'd0) begin
          if (mode_r == ST_IDLE) begin
            if (inq_r.key_code == kcl_pkg::KEY_STAR) begin
              mode_nxt = ST_CHECK;
              keys_nxt = '0;
              pos_nxt  = '0;
              ev       = kcl_pkg::EV_KEY;
            end else if (inq_r.key_code == kcl_pkg::KEY_HASH) begin
              mode_nxt = ST_OLD;
              keys_nxt = '0;
              pos_nxt  = '0;
              ev       = kcl_pkg::EV_KEY;
            end
          end else if (!key_done) begin
            keys_nxt = keys_wr;
            pos_nxt  = pos_inc;
            ev       = kcl_pkg::EV_KEY;
          end else begin
            // entry finished: buffer always goes back to blank
            keys_nxt = '0;
            pos_nxt  = '0;
            case (mode_r)
              ST_NEW: begin
                saved_nxt = keys_wr;
                mode_nxt  = ST_IDLE;
                ev        = kcl_pkg::EV_SAVED;
              end
              ST_CHECK: begin
                mode_nxt = ST_IDLE;
                if (key_match) begin
                  cnt_nxt = cfg.open_seconds;
                  ev      = kcl_pkg::EV_PW_OK;
                end else begin
                  ev = kcl_pkg::EV_PW_WRONG;
                end
              end
              default: begin
                if (key_match) begin
                  mode_nxt = ST_NEW;
                  ev       = kcl_pkg::EV_NEW_PW;
                end else begin
                  mode_nxt = ST_IDLE;
                  ev       = kcl_pkg::EV_PW_WRONG;
                end
              end
            endcase
          end
        end
      end
      kcl_pkg::CMD_TAG: begin
        if (cnt_r == 8'd0) begin
          tag_nxt = tag_wr;
          if (tpos_inc != (kcl_pkg::TAG_IDX_W+1)'(kcl_pkg::TAG_BYTES)) begin
            tpos_nxt = tpos_inc[kcl_pkg::TAG_IDX_W-1:0];
          end else begin
            tpos_nxt = '0;
            if (tag_match) begin
              mode_nxt = ST_IDLE;
              keys_nxt = '0;
              pos_nxt  = '0;
              cnt_nxt  = cfg.open_seconds;
              ev       = kcl_pkg::EV_TAG_OK;
            end else begin
              ev = kcl_pkg::EV_TAG_WRONG;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= ST_IDLE;
      keys_r      <= '0;
      saved_r     <= '0;
      pos_r       <= '0;
      tag_r       <= '0;
      tpos_r      <= '0;
      cnt_r       <= 8'd0;
    end else begin
      if (in_ready) begin
        inq_valid_r <= in_valid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        mode_r      <= mode_nxt;
        keys_r      <= keys_nxt;
        saved_r     <= saved_nxt;
        pos_r       <= pos_nxt;
        tag_r       <= tag_nxt;
        tpos_r      <= tpos_nxt;
        cnt_r       <= cnt_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_r <= in_item;
    end
    if (fire) begin
      res_r.door_open    <= (cnt_nxt != 8'd0);
      res_r.seconds_left <= cnt_nxt;
      res_r.event_res    <= ev;
      res_r.mode_now     <= mode_nxt;
      res_r.keys_entered <= 5'(pos_nxt);
    end
  end

endmodule

// ===== sv/keypad_rfid_code_lock.sv =====
// Keypad and RFID code lock. Each input beat is one event: a debounced key
// (in_cmd 0), one tag byte from the reader (in_cmd 1) or a one-second tick
// (in_cmd 2); every event gives exactly one output beat with the door state,
// countdown, event code, mode and number of keys collected. In idle, '*'
// starts a password check and '#' starts a password change; an entry ends
// after sixteen keys or at '#'; it is compared against the saved password,
// or saved as the new one at the end of a change. A full twelve-byte tag
// equal to the reference also opens the door; while it is open only ticks
// act. A beat passes the input register, then the result register; a new
// beat can be taken every cycle while the output is not stalled, as the
// decision is one pass of logic between the two registers, with buffer and
// tag compares in parallel. APB-style registers sit at byte addresses 0x00
// (open_seconds), 0x08 (reference tag bytes 0-5) and 0x10 (bytes 6-11).
module keypad_rfid_code_lock (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kcl_pkg::ADDR_W-1:0] paddr,
  input  logic [kcl_pkg::DATA_W-1:0] pwdata,
  output logic [kcl_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  // event beats in
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_cmd,
  input  logic [3:0]                 in_key_code,
  input  logic [7:0]                 in_rfid_byte,
  // result beats out
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_door_open,
  output logic [7:0]                 out_seconds_left,
  output logic [2:0]                 out_event_res,
  output logic [1:0]                 out_mode_now,
  output logic [4:0]                 out_keys_entered
);

  kcl_pkg::cfg_t  cfg;
  kcl_pkg::item_t in_item;
  kcl_pkg::res_t  out_res;

  // pack the event fields for the core
  assign in_item.cmd       = in_cmd;
  assign in_item.key_code  = in_key_code;
  assign in_item.rfid_byte = in_rfid_byte;

  // registers read live by core; user writes only when quiet, unenforced
  kcl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // lock state, entry buffer, tag buffer and the two beat registers
  kcl_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // unpack the result beat
  assign out_door_open    = out_res.door_open;
  assign out_seconds_left = out_res.seconds_left;
  assign out_event_res    = out_res.event_res;
  assign out_mode_now     = out_res.mode_now;
  assign out_keys_entered = out_res.keys_entered;

endmodule

// ===== sv/kcl_checker.sv =====
module kcl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_door_open,
  input logic [7:0] out_seconds_left,
  input logic [2:0] out_event_res,
  input logic [1:0] out_mode_now,
  input logic [4:0] out_keys_entered
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // door flag follows the countdown
  a_door_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_door_open == (out_seconds_left != 8'd0)))
    else $error("door flag disagrees with countdown");

  // idle never holds a partial entry
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_mode_now == kcl_pkg::MODE_IDLE) |-> (out_keys_entered == 5'd0))
    else $error("keys left in buffer while idle");

  // saving a password returns to idle
  a_saved_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == kcl_pkg::EV_SAVED) |->
      (out_mode_now == kcl_pkg::MODE_IDLE))
    else $error("still in entry after password save");

  // an open door never reports entry progress
  a_open_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_door_open |->
      (out_event_res == kcl_pkg::EV_NONE || out_event_res == kcl_pkg::EV_PW_OK ||
       out_event_res == kcl_pkg::EV_TAG_OK))
    else $error("event reported while door open");

endmodule

bind keypad_rfid_code_lock kcl_checker u_kcl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_door_open    (out_door_open),
  .out_seconds_left (out_seconds_left),
  .out_event_res    (out_event_res),
  .out_mode_now     (out_mode_now),
  .out_keys_entered (out_keys_entered)
);
